@@ rtl/tvm_pkg.sv @@
// ---------------------------------------------------------------------------
// tvm_pkg
// shared types and constants of the virtual machine step unit
// ---------------------------------------------------------------------------
package tvm_pkg;

	localparam int unsigned MemDepthDefault = 2048;

	localparam logic [1:0] ModeLoadReg = 2'd0;
	localparam logic [1:0] ModeLoadMem = 2'd1;
	localparam logic [1:0] ModeStep    = 2'd2;

	localparam logic [1:0] StOk     = 2'd0;
	localparam logic [1:0] StDivZ   = 2'd1;
	localparam logic [1:0] StUnsup  = 2'd2;
	localparam logic [1:0] StRange  = 2'd3;

	localparam logic [3:0] RegDs = 4'd2;
	localparam logic [3:0] RegEs = 4'd3;
	localparam logic [3:0] RegIp = 4'd4;
	localparam logic [3:0] RegCc = 4'd9;
	localparam logic [3:0] RegAx = 4'd10;

	localparam logic [7:0] KindImm = 8'd0;
	localparam logic [7:0] KindReg = 8'd1;
	localparam logic [7:0] KindDir = 8'd2;

	localparam logic [15:0] OpMov  = 16'h01;
	localparam logic [15:0] OpAdd  = 16'h02;
	localparam logic [15:0] OpSub  = 16'h03;
	localparam logic [15:0] OpMul  = 16'h04;
	localparam logic [15:0] OpDiv  = 16'h05;
	localparam logic [15:0] OpMod  = 16'h06;
	localparam logic [15:0] OpCmp  = 16'h13;
	localparam logic [15:0] OpSwap = 16'h17;
	localparam logic [15:0] OpJmp  = 16'h20;
	localparam logic [15:0] OpJe   = 16'h21;
	localparam logic [15:0] OpJg   = 16'h22;
	localparam logic [15:0] OpJl   = 16'h23;
	localparam logic [15:0] OpJz   = 16'h24;
	localparam logic [15:0] OpJp   = 16'h25;
	localparam logic [15:0] OpJn   = 16'h26;
	localparam logic [15:0] OpJnz  = 16'h27;
	localparam logic [15:0] OpJnp  = 16'h28;
	localparam logic [15:0] OpJnn  = 16'h29;
	localparam logic [15:0] OpAnd  = 16'h31;
	localparam logic [15:0] OpOr   = 16'h32;
	localparam logic [15:0] OpNot  = 16'h33;
	localparam logic [15:0] OpXor  = 16'h34;
	localparam logic [15:0] OpShl  = 16'h37;
	localparam logic [15:0] OpShr  = 16'h38;
	localparam logic [15:0] OpRet  = 16'h8f;

	localparam logic [31:0] CcZero = 32'h0000_0001;
	localparam logic [31:0] CcNeg  = 32'h0000_1000;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] flags_of(input logic [31:0] r);
		if (r == 32'd0)
			return CcZero;
		else if (r[31])
			return CcNeg;
		return 32'd0;
	endfunction

	// 3*(n-1) with wrap
	function automatic logic [31:0] line_target(input logic [31:0] n);
		logic [31:0] m;
		m = n - 32'd1;
		return {m[30:0], 1'b0} + m;
	endfunction

endpackage

@@ rtl/tvm_div.sv @@
// ---------------------------------------------------------------------------
// tvm_div
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tvm_div
	import tvm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quot_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q  <= trial[31:0];
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[30:0], quot_q[31]};
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

@@ rtl/teaching_vm_instruction_step_unit.sv @@
// ---------------------------------------------------------------------------
// teaching_vm_instruction_step_unit
// register file plus word memory; executes one machine instruction per step word
// ---------------------------------------------------------------------------
// load words pass through S_OUT before their result shows on valid_out
// a step walks S_F0-S_F3, S_DEC, S_OP1, S_OP2, S_EXEC, S_WB1, S_WB2, S_OUT; div and mod wait in S_DIVW for the divider
// one word in flight at a time; the next word waits until the result has left
// reset clears the register file; memory contents are undefined until loaded
module teaching_vm_instruction_step_unit
	import tvm_pkg::*;
#(
	parameter int unsigned MEM_DEPTH = MemDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	output logic               stall_in,
	input  logic [1:0]         mode,
	input  logic [10:0]        address,
	input  logic signed [31:0] value,
	output logic               valid_out,
	input  logic               stall_out,
	output logic signed [31:0] ip,
	output logic [12:0]        cc,
	output logic signed [31:0] result_value,
	output logic               halted,
	output logic [1:0]         status
);

	localparam int AW = $clog2(MEM_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_F0, S_F1, S_F2, S_F3, S_DEC, S_OP1, S_OP2, S_EXEC,
		S_DIVW, S_WB1, S_WB2, S_OUT
	} state_t;

	state_t state_q;

	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] rf_q [16];
	logic [31:0] rdata_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;

	logic [10:0] addr_q;
	logic [31:0] val_q;
	logic [31:0] ctl_q, w1_q, w2_q, a1_q, a2_q, pc_q, res_q;
	logic [31:0] l1_q, l2_q;
	logic [1:0]  st_q;
	logic        halt_q;
	logic        outv_q;
	logic        na_q, nb_q;

	div_req_t dreq;
	div_rsp_t drsp;

	tvm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// helpers
	logic [15:0] op;
	logic [7:0]  k1, k2;
	assign op = ctl_q[31:16];
	assign k1 = ctl_q[15:8];
	assign k2 = ctl_q[7:0];

	logic [31:0] pc_r, ds_r;
	assign pc_r = rf_q[RegIp];
	assign ds_r = rf_q[RegDs];

	function automatic logic [31:0] dir_addr(input logic [31:0] raw, input logic [31:0] ds,
			input logic [31:0] es);
		return ((raw[31:28] == 4'h2) ? ds : es) + {4'h0, raw[27:0]};
	endfunction

	logic [31:0] d1, d2;
	assign d1 = dir_addr(w1_q, rf_q[RegDs], rf_q[RegEs]);
	assign d2 = dir_addr(w2_q, rf_q[RegDs], rf_q[RegEs]);

	// execute combinational
	logic [31:0] ex_a1, ex_a2, ex_pc, ex_cc, cc_r, prod;
	logic        ex_flag, ex_unsup, ex_jmp;
	assign cc_r = rf_q[RegCc];
	assign prod = a1_q * a2_q;

	always_comb begin
		ex_a1 = a1_q;
		ex_a2 = a2_q;
		ex_pc = pc_q;
		ex_cc = cc_r;
		ex_flag = 1'b0;
		ex_unsup = 1'b0;
		ex_jmp = 1'b0;
		case (op)
			OpMov: ex_a1 = a2_q;
			OpAdd: begin ex_a1 = a1_q + a2_q; ex_flag = 1'b1; end
			OpSub: begin ex_a1 = a1_q - a2_q; ex_flag = 1'b1; end
			OpMul: begin ex_a1 = prod; ex_flag = 1'b1; end
			OpCmp: ex_cc = flags_of(a1_q - a2_q);
			OpSwap: begin ex_a1 = a2_q; ex_a2 = a1_q; end
			OpAnd: begin ex_a1 = a1_q & a2_q; ex_flag = 1'b1; end
			OpOr:  begin ex_a1 = a1_q | a2_q; ex_flag = 1'b1; end
			OpNot: begin ex_a1 = (a1_q == 32'd0) ? 32'd1 : 32'd0; ex_flag = 1'b1; end
			OpXor: begin ex_a1 = a1_q ^ a2_q; ex_flag = 1'b1; end
			OpShl: begin
				ex_a1 = (a2_q >= 32'd32) ? 32'd0 : (a1_q << a2_q[4:0]);
				ex_flag = 1'b1;
			end
			OpShr: begin
				ex_a1 = (a2_q >= 32'd32) ? {32{a1_q[31]}} :
					32'($signed(a1_q) >>> a2_q[4:0]);
				ex_flag = 1'b1;
			end
			OpJmp: ex_pc = line_target(a1_q);
			OpJe: if (a1_q == rf_q[RegAx]) ex_pc = line_target(a2_q);
			OpJg: if ($signed(a1_q) > $signed(rf_q[RegAx])) ex_pc = line_target(a2_q);
			OpJl: if ($signed(a1_q) < $signed(rf_q[RegAx])) ex_pc = line_target(a2_q);
			OpJz:  ex_jmp = (cc_r & 32'hfff1) == 32'h1;
			OpJp:  ex_jmp = (cc_r & 32'h1fff) == 32'h0;
			OpJn:  ex_jmp = (cc_r & 32'h1fff) == 32'h1000;
			OpJnz: ex_jmp = (cc_r & 32'hfff1) == 32'h0;
			OpJnp: ex_jmp = ((cc_r & 32'h1fff) == 32'h1000) || ((cc_r & 32'hfff1) == 32'h1);
			OpJnn: ex_jmp = ((cc_r & 32'h1fff) == 32'h0) || ((cc_r & 32'hfff1) == 32'h1);
			OpRet: ex_pc = ds_r;
			default: ex_unsup = 1'b1;
		endcase
		if (ex_jmp)
			ex_pc = line_target(a1_q);
		if (ex_flag)
			ex_cc = flags_of(ex_a1);
		if (ex_pc == pc_q)
			ex_pc = pc_q + 32'd3;
	end

	logic is_div;
	assign is_div = (op == OpDiv) || (op == OpMod);
	logic [31:0] div_res;
	always_comb begin
		if (op == OpDiv)
			div_res = (na_q != nb_q) ? 32'd0 - drsp.quot : drsp.quot;
		else
			div_res = na_q ? 32'd0 - drsp.rem : drsp.rem;
	end

	assign dreq.start = (state_q == S_EXEC) && is_div && (a2_q != 32'd0);
	assign dreq.dividend = a1_q[31] ? 32'd0 - a1_q : a1_q;
	assign dreq.divisor  = a2_q[31] ? 32'd0 - a2_q : a2_q;

	// new words wait while busy or while the previous result is still held
	assign stall_in = (state_q != S_IDLE) || outv_q;

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = addr_q[AW-1:0];
		wdata = val_q;
		raddr = pc_r[AW-1:0];
		case (state_q)
			S_F0: raddr = pc_r[AW-1:0];
			S_F1: raddr = AW'(pc_r + 32'd1);
			S_F2: raddr = AW'(pc_r + 32'd2);
			S_DEC: raddr = d1[AW-1:0];
			S_OP1: raddr = d2[AW-1:0];
			S_IDLE: begin
				we = valid_in && !stall_in && (mode == ModeLoadMem) &&
					(32'(address) < MEM_DEPTH);
				waddr = AW'(address);
				wdata = value;
			end
			S_WB1: begin
				we = (k1 == KindDir);
				waddr = l1_q[AW-1:0];
				wdata = res_q;
			end
			S_WB2: begin
				we = (op == OpSwap) && (k2 == KindDir);
				waddr = l2_q[AW-1:0];
				wdata = a2_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			outv_q  <= 1'b0;
			for (int i = 0; i < 16; i++)
				rf_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (valid_in && !stall_in) begin
					addr_q <= address;
					val_q  <= value;
					res_q  <= '0;
					st_q   <= StOk;
					halt_q <= 1'b0;
					case (mode)
						ModeLoadReg: begin
							if (address < 11'd16) begin
								rf_q[address[3:0]] <= value;
								res_q <= value;
							end else
								st_q <= StRange;
							state_q <= S_OUT;
						end
						ModeLoadMem: begin
							if (32'(address) < MEM_DEPTH)
								res_q <= value;
							else
								st_q <= StRange;
							state_q <= S_OUT;
						end
						ModeStep: begin
							pc_q <= pc_r;
							if (pc_r[31] || ($signed(pc_r) >= $signed(ds_r))) begin
								halt_q  <= 1'b1;
								state_q <= S_OUT;
							end else if (pc_r >= MEM_DEPTH || pc_r + 32'd2 >= MEM_DEPTH) begin
								st_q    <= StRange;
								state_q <= S_OUT;
							end else
								state_q <= S_F0;
						end
						default: begin
							st_q    <= StUnsup;
							state_q <= S_OUT;
						end
					endcase
				end
				S_F0: state_q <= S_F1;
				S_F1: begin ctl_q <= rdata_q; state_q <= S_F2; end
				S_F2: begin w1_q <= rdata_q; state_q <= S_F3; end
				S_F3: begin w2_q <= rdata_q; state_q <= S_DEC; end
				S_DEC: begin
					// operand one is resolved fully before operand two
					if (k1 > KindDir) begin
						st_q <= StUnsup; state_q <= S_OUT;
					end else if (k1 == KindDir && d1 >= MEM_DEPTH) begin
						st_q <= StRange; state_q <= S_OUT;
					end else if (k2 > KindDir) begin
						st_q <= StUnsup; state_q <= S_OUT;
					end else if (k2 == KindDir && d2 >= MEM_DEPTH) begin
						st_q <= StRange; state_q <= S_OUT;
					end else begin
						l1_q <= (k1 == KindReg) ? {28'd0, w1_q[3:0]} : d1;
						l2_q <= (k2 == KindReg) ? {28'd0, w2_q[3:0]} : d2;
						state_q <= S_OP1;
					end
				end
				S_OP1: begin
					case (k1)
						KindImm: a1_q <= w1_q;
						KindReg: a1_q <= rf_q[l1_q[3:0]];
						default: a1_q <= rdata_q;
					endcase
					state_q <= S_OP2;
				end
				S_OP2: begin
					case (k2)
						KindImm: a2_q <= w2_q;
						KindReg: a2_q <= rf_q[l2_q[3:0]];
						default: a2_q <= rdata_q;
					endcase
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					na_q <= a1_q[31];
					nb_q <= a2_q[31];
					if (is_div) begin
						if (a2_q == 32'd0) begin
							st_q <= StDivZ; state_q <= S_OUT;
						end else
							state_q <= S_DIVW;
					end else if (ex_unsup) begin
						st_q <= StUnsup; state_q <= S_OUT;
					end else begin
						res_q   <= ex_a1;
						a2_q    <= ex_a2;
						rf_q[RegIp] <= ex_pc;
						rf_q[RegCc] <= ex_cc;
						state_q <= S_WB1;
					end
				end
				S_DIVW: if (drsp.done) begin
					res_q <= div_res;
					rf_q[RegCc] <= flags_of(div_res);
					rf_q[RegIp] <= pc_q + 32'd3;
					state_q <= S_WB1;
				end
				S_WB1: begin
					// operand writes land after ip and cc, so they win
					if (k1 == KindReg)
						rf_q[l1_q[3:0]] <= res_q;
					state_q <= S_WB2;
				end
				S_WB2: begin
					if (op == OpSwap && k2 == KindReg)
						rf_q[l2_q[3:0]] <= a2_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					outv_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q != S_OUT && outv_q && !stall_out)
				outv_q <= 1'b0;
		end
	end

	assign valid_out    = outv_q;
	assign ip           = rf_q[RegIp];
	assign cc           = rf_q[RegCc][12:0];
	assign result_value = res_q;
	assign halted       = halt_q;
	assign status       = st_q;

	// S_OUT only entered when the output register is free
	ast_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !outv_q) else $error("out stage");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && stall_out) |=> valid_out && $stable(result_value) &&
		$stable(status) && $stable(ip) && $stable(cc) && $stable(halted))
		else $error("result changed while stalled");
	ast_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIVW) else $error("divider done outside wait");
	ast_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> stall_in) else $error("accept while busy");

endmodule
